### hw/rtl/svm_kernel_matrix_entry_macros.svh
// Assertion helpers for the kernel matrix entry unit
`ifndef SVM_KERNEL_MATRIX_ENTRY_MACROS_SVH
`define SVM_KERNEL_MATRIX_ENTRY_MACROS_SVH
`ifndef SYNTHESIS
`define SKME_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("skme: forbidden condition seen");
`define SKME_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("skme: implication violated");
`else
`define SKME_NEVER(lbl, cond)
`define SKME_IMPLIES(lbl, ante, cons)
`endif
`endif

### hw/rtl/skme_pkg.sv
package skme_pkg;

	localparam int MAX_POINTS   = 256;
	localparam int MAX_FEATURES = 64;
	localparam int FRAC_BITS    = 16;

	localparam int VAL_W     = 32;
	localparam int PT_W      = $clog2(MAX_POINTS);
	localparam int FT_W      = $clog2(MAX_FEATURES);
	localparam int FEAT_AW   = PT_W + FT_W;
	localparam int FEAT_DEPTH = MAX_POINTS * MAX_FEATURES;
	localparam int NPTS_W    = 9;
	localparam int NFEAT_W   = 7;
	localparam int DEG_W     = 4;
	localparam int MODE_W    = 2;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 3;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 64;
	localparam int DIST_W = ACC_W - FRAC_BITS;
	localparam int HALF_W = DIST_W / 2;
	localparam int HP_W   = VAL_W + HALF_W;
	localparam int XP_W   = VAL_W + DIST_W;
	localparam int XM_W   = FRAC_BITS + 7;
	localparam int T_W    = 26;
	localparam int N_W    = T_W - FRAC_BITS;
	localparam int S_W    = N_W + 1;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_FEAT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_Q    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_COMP = 2'd2;

	localparam logic [MODE_W-1:0] MODE_POLY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RBF  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEAT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY_DEG    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_ZERO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_QA_COST     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAG_COST   = 3'd7;

	localparam logic signed [VAL_W-1:0] FX_ONE = VAL_W'(1) << FRAC_BITS;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [30:0] Q30_ONE   = 31'd1 << 30;
	localparam logic [XM_W-1:0] XM_MAX = XM_W'(64) << FRAC_BITS;

	typedef struct packed {
		logic [MODE_W-1:0]         kernel_mode;
		logic [NPTS_W-1:0]         num_points;
		logic [NFEAT_W-1:0]        feat_use;
		logic [DEG_W-1:0]          poly_degree;
		logic signed [VAL_W-1:0]   gamma_value;
		logic signed [VAL_W-1:0]   coef_zero;
		logic signed [VAL_W-1:0]   qa_cost_value;
		logic signed [VAL_W-1:0]   diag_cost;
	} cfg_t;

	typedef struct packed {
		logic [REQ_W-1:0]        kind;
		logic                    oor;
		logic [PT_W-1:0]         point;
		logic [FT_W-1:0]         feat;
		logic signed [VAL_W-1:0] value;
		logic [PT_W-1:0]         row;
		logic [PT_W-1:0]         col;
	} item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DOT, S_DRAIN, S_KSEL, S_WAIT, S_RHI, S_RX, S_EXPT, S_EXPZ,
		S_H0, S_H1, S_H2, S_EXPS, S_PBASE, S_PLOOP, S_PUPD, S_FIN
	} bk_state_t;

	function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
		return !((&v[ACC_W-1:VAL_W-1]) || !(|v[ACC_W-1:VAL_W-1]));
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (!ovf32(v))
			r = v[VAL_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(VAL_W-1){1'b0}}};
		else
			r = {1'b0, {(VAL_W-1){1'b1}}};
		return r;
	endfunction

	// floor(2^32 / k), for the Horner divide steps
	function automatic logic [31:0] recip(input logic [3:0] k);
		logic [31:0] r;
		case (k)
			4'd2: r = 32'd2147483648;
			4'd3: r = 32'd1431655765;
			4'd4: r = 32'd1073741824;
			4'd5: r = 32'd858993459;
			4'd6: r = 32'd715827882;
			4'd7: r = 32'd613566756;
			4'd8: r = 32'd536870912;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/skme_ram.sv
module skme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/skme_front.sv
module skme_front import skme_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [PT_W-1:0]         point_index,
	input  logic [FT_W-1:0]         feature_index,
	input  logic signed [VAL_W-1:0] load_value,
	input  logic [PT_W-1:0]         row_index,
	input  logic [PT_W-1:0]         col_index,
	input  logic [NPTS_W-1:0]       num_points,
	output item_t                   head,
	output logic                    head_vld,
	input  logic                    pop
);

	item_t              slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic [NPTS_W-1:0]  lim;
	logic               push;
	item_t              item;

	assign busy = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign lim  = (num_points > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) : num_points;
	// drop the unused request code here
	assign push = start && !busy
		&& (req_type == REQ_FEAT || req_type == REQ_Q || req_type == REQ_COMP);

	always_comb begin
		item.kind  = req_type;
		item.oor   = ({1'b0, row_index} >= lim) || ({1'b0, col_index} >= lim);
		item.point = point_index;
		item.feat  = feature_index;
		item.value = load_value;
		item.row   = row_index;
		item.col   = col_index;
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head     = slot_q[rd_ptr_q];
	assign head_vld = (cnt_q != '0);

endmodule

### hw/rtl/skme_back.sv
module skme_back import skme_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  item_t                   head,
	input  logic                    head_vld,
	output logic                    pop,
	output logic                    done,
	output logic signed [VAL_W-1:0] entry_value,
	output logic [PT_W-1:0]         row_out,
	output logic [PT_W-1:0]         col_out,
	output logic [STAT_W-1:0]       entry_status
);

	bk_state_t state_q, state_d, ret_q, ret_d;

	logic [PT_W-1:0]    row_q, col_q;
	logic [NFEAT_W-1:0] feat_q, nf;
	logic               vld_s1, vld_s2, vld_s3;
	logic signed [MUL_W-1:0]  op_a_s2, op_b_s2, mul_a_d, mul_b_d;
	logic signed [PROD_W-1:0] prod_s3;
	logic               mul_ld;
	logic [ACC_W-1:0]   acc_q;
	logic               sat_q;
	logic signed [ACC_W-1:0] kval_q;
	logic signed [VAL_W+2:0] off_q;
	logic signed [VAL_W-1:0] base_q, pw_q;
	logic [DEG_W-1:0]   cnt_q;
	logic [HP_W-1:0]    lo_q;
	logic [29:0]        z_q;
	logic [30:0]        p_q, v_q;
	logic [3:0]         k_q;
	logic signed [N_W-1:0] n_q;

	logic               done_q;
	logic signed [VAL_W-1:0] value_q;
	logic [PT_W-1:0]    row_out_q, col_out_q;
	logic [STAT_W-1:0]  status_q;

	logic signed [VAL_W-1:0] fa, fb, qr, qc;
	logic               feat_we, q_we, rd_feat;
	logic [FEAT_AW-1:0] feat_waddr;

	// datapath helpers
	logic signed [MUL_W-1:0] diff, dmag, gmag, gsx;
	logic signed [ACC_W-1:0] dot_w, p64, pu, pb, fin, exp_val;
	logic signed [VAL_W-1:0] d32;
	logic [DIST_W-1:0]  sq_dist;
	logic [XP_W-1:0]    full_w;
	logic [XM_W-1:0]    xm;
	logic signed [XM_W:0] x_w;
	logic signed [ACC_W-1:0] t64;
	logic signed [T_W-1:0] t_w;
	logic [30:0]        v_w, q0, q1;
	logic [34:0]        rem;
	logic signed [S_W-1:0] s_w, ns;
	logic [61:0]        shl;
	logic               exp_ovf;
	logic [ACC_W:0]     usum;
	logic signed [ACC_W-1:0] ssum;

	assign nf = (cfg.feat_use > NFEAT_W'(MAX_FEATURES)) ? NFEAT_W'(MAX_FEATURES)
		: cfg.feat_use;

	assign feat_we    = pop && head.kind == REQ_FEAT;
	assign q_we       = pop && head.kind == REQ_Q;
	assign feat_waddr = {head.point, head.feat};
	assign rd_feat    = (state_q == S_DOT);

	// row and column copies give two feature reads per cycle
	skme_ram #(.WIDTH(VAL_W), .DEPTH(FEAT_DEPTH)) u_feat_row (
		.clk(clk), .we(feat_we), .waddr(feat_waddr), .wdata(head.value),
		.re(rd_feat), .raddr({row_q, feat_q[FT_W-1:0]}), .rdata(fa)
	);
	skme_ram #(.WIDTH(VAL_W), .DEPTH(FEAT_DEPTH)) u_feat_col (
		.clk(clk), .we(feat_we), .waddr(feat_waddr), .wdata(head.value),
		.re(rd_feat), .raddr({col_q, feat_q[FT_W-1:0]}), .rdata(fb)
	);
	skme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_q_row (
		.clk(clk), .we(q_we), .waddr(head.point), .wdata(head.value),
		.re(pop), .raddr(head.row), .rdata(qr)
	);
	skme_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_q_col (
		.clk(clk), .we(q_we), .waddr(head.point), .wdata(head.value),
		.re(pop), .raddr(head.col), .rdata(qc)
	);

	always_comb begin
		diff   = MUL_W'(fa) - MUL_W'(fb);
		dmag   = diff[MUL_W-1] ? -diff : diff;
		gsx    = MUL_W'(cfg.gamma_value);
		gmag   = gsx[MUL_W-1] ? -gsx : gsx;
		dot_w  = $signed(acc_q) >>> FRAC_BITS;
		d32    = sat32(dot_w);
		sq_dist = DIST_W'(acc_q >> FRAC_BITS);
		p64    = prod_s3[ACC_W-1:0];
		pu     = p64 >>> FRAC_BITS;
		pb     = pu + ACC_W'(cfg.coef_zero);
		full_w = {prod_s3[HP_W-1:0], {HALF_W{1'b0}}} + XP_W'(lo_q);
		if ((full_w >> FRAC_BITS) > XP_W'(XM_MAX))
			xm = XM_MAX;
		else
			xm = full_w[XM_W+FRAC_BITS-1:FRAC_BITS];
		x_w    = cfg.gamma_value[VAL_W-1] ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
		t64    = p64 >>> 30;
		t_w    = t64[T_W-1:0];
		v_w    = prod_s3[60:30];
		q0     = prod_s3[62:32];
		rem    = 35'(v_q) - (35'(q0) * 35'(k_q));
		q1     = (rem >= 35'(k_q)) ? q0 + 31'd1 : q0;
		s_w    = S_W'(30 - FRAC_BITS) + S_W'(n_q);
		ns     = -s_w;
		shl    = 62'(p_q) << ns[4:0];
		exp_ovf = 1'b0;
		if (!s_w[S_W-1]) begin
			if (s_w >= S_W'(63))
				exp_val = '0;
			else
				exp_val = ACC_W'(p_q >> s_w[5:0]);
		end else if (ns > S_W'(31) || shl > 62'h7FFF_FFFF) begin
			exp_val = ACC_W'(32'h7FFF_FFFF);
			exp_ovf = 1'b1;
		end else begin
			exp_val = ACC_W'(shl);
		end
		fin    = kval_q + ACC_W'(off_q);
		usum   = {1'b0, acc_q} + {1'b0, prod_s3[ACC_W-1:0]};
		ssum   = $signed(acc_q) + p64;
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		pop     = 1'b0;
		mul_ld  = 1'b0;
		mul_a_d = '0;
		mul_b_d = '0;
		case (state_q)
			S_IDLE: begin
				if (head_vld) begin
					pop = 1'b1;
					if (head.kind == REQ_COMP && !head.oor)
						state_d = (nf == '0) ? S_DRAIN : S_DOT;
				end
			end
			S_DOT: begin
				if (feat_q + 1'b1 == nf)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!vld_s1 && !vld_s2 && !vld_s3)
					state_d = S_KSEL;
			end
			S_KSEL: begin
				case (cfg.kernel_mode)
					MODE_POLY: begin
						mul_ld  = 1'b1;
						mul_a_d = gsx;
						mul_b_d = MUL_W'(d32);
						ret_d   = S_PBASE;
						state_d = S_WAIT;
					end
					MODE_RBF: begin
						mul_ld  = 1'b1;
						if (cfg.gamma_value == '0) begin
							mul_a_d = '0;
							mul_b_d = MUL_W'(LOG2E_Q30);
							ret_d   = S_EXPT;
						end else begin
							mul_a_d = gmag;
							mul_b_d = MUL_W'(sq_dist[HALF_W-1:0]);
							ret_d   = S_RHI;
						end
						state_d = S_WAIT;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_WAIT: state_d = ret_q;
			S_RHI: begin
				mul_ld  = 1'b1;
				mul_a_d = gmag;
				mul_b_d = MUL_W'(sq_dist[DIST_W-1:HALF_W]);
				ret_d   = S_RX;
				state_d = S_WAIT;
			end
			S_RX: begin
				mul_ld  = 1'b1;
				mul_a_d = MUL_W'(x_w);
				mul_b_d = MUL_W'(LOG2E_Q30);
				ret_d   = S_EXPT;
				state_d = S_WAIT;
			end
			S_EXPT: begin
				mul_ld  = 1'b1;
				mul_a_d = MUL_W'({t_w[FRAC_BITS-1:0], {(30 - FRAC_BITS){1'b0}}});
				mul_b_d = MUL_W'(LN2_Q30);
				ret_d   = S_EXPZ;
				state_d = S_WAIT;
			end
			S_EXPZ: state_d = S_H0;
			S_H0: begin
				mul_ld  = 1'b1;
				mul_a_d = MUL_W'(z_q);
				mul_b_d = MUL_W'(p_q);
				ret_d   = S_H1;
				state_d = S_WAIT;
			end
			S_H1: begin
				if (k_q == 4'd1) begin
					state_d = S_EXPS;
				end else begin
					mul_ld  = 1'b1;
					mul_a_d = MUL_W'(v_w);
					mul_b_d = MUL_W'(recip(k_q));
					ret_d   = S_H2;
					state_d = S_WAIT;
				end
			end
			S_H2:    state_d = S_H0;
			S_EXPS:  state_d = S_FIN;
			S_PBASE: state_d = S_PLOOP;
			S_PLOOP: begin
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end else begin
					mul_ld  = 1'b1;
					mul_a_d = MUL_W'(pw_q);
					mul_b_d = MUL_W'(base_q);
					ret_d   = S_PUPD;
					state_d = S_WAIT;
				end
			end
			S_PUPD:  state_d = S_PLOOP;
			S_FIN:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			vld_s1  <= rd_feat;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_q  <= (pop && head.kind == REQ_COMP && head.oor) || (state_q == S_FIN);
		end
	end

	// shared multiplier: dot operands win, the sequencer uses it after the dot product
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (cfg.kernel_mode == MODE_RBF) begin
				op_a_s2 <= dmag;
				op_b_s2 <= dmag;
			end else begin
				op_a_s2 <= MUL_W'(fa);
				op_b_s2 <= MUL_W'(fb);
			end
		end else if (mul_ld) begin
			op_a_s2 <= mul_a_d;
			op_b_s2 <= mul_b_d;
		end
		prod_s3 <= op_a_s2 * op_b_s2;

		if (vld_s3) begin
			if (cfg.kernel_mode == MODE_RBF) begin
				if (usum[ACC_W]) begin
					acc_q <= '1;
					sat_q <= 1'b1;
				end else begin
					acc_q <= usum[ACC_W-1:0];
				end
			end else if (acc_q[ACC_W-1] == p64[ACC_W-1] && ssum[ACC_W-1] != p64[ACC_W-1]) begin
				acc_q <= p64[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
				sat_q <= 1'b1;
			end else begin
				acc_q <= ssum;
			end
		end

		case (state_q)
			S_IDLE: begin
				if (pop) begin
					row_q     <= head.row;
					col_q     <= head.col;
					feat_q    <= '0;
					acc_q     <= '0;
					sat_q     <= 1'b0;
					value_q   <= '0;
					row_out_q <= head.row;
					col_out_q <= head.col;
					status_q  <= STAT_RANGE;
				end
			end
			S_DOT: feat_q <= feat_q + 1'b1;
			S_KSEL: begin
				kval_q <= dot_w;
				off_q  <= (VAL_W+3)'(cfg.qa_cost_value) - (VAL_W+3)'(qr) - (VAL_W+3)'(qc)
					+ ((row_q == col_q) ? (VAL_W+3)'(cfg.diag_cost) : '0);
				if (cfg.kernel_mode == MODE_POLY && ovf32(dot_w))
					sat_q <= 1'b1;
			end
			S_RHI: lo_q <= prod_s3[HP_W-1:0];
			S_EXPT: n_q <= N_W'(t_w >>> FRAC_BITS);
			S_EXPZ: begin
				z_q <= prod_s3[59:30];
				p_q <= Q30_ONE;
				k_q <= 4'd8;
			end
			S_H1: begin
				if (k_q == 4'd1)
					p_q <= Q30_ONE - v_w;
				else
					v_q <= v_w;
			end
			S_H2: begin
				p_q <= Q30_ONE - q1;
				k_q <= k_q - 4'd1;
			end
			S_EXPS: begin
				kval_q <= exp_val;
				if (exp_ovf)
					sat_q <= 1'b1;
			end
			S_PBASE: begin
				base_q <= sat32(pb);
				pw_q   <= FX_ONE;
				cnt_q  <= cfg.poly_degree;
				if (ovf32(pb))
					sat_q <= 1'b1;
			end
			S_PLOOP: begin
				if (cnt_q == '0)
					kval_q <= ACC_W'(pw_q);
			end
			S_PUPD: begin
				pw_q  <= sat32(pu);
				cnt_q <= cnt_q - 1'b1;
				if (ovf32(pu))
					sat_q <= 1'b1;
			end
			S_FIN: begin
				value_q   <= sat32(fin);
				row_out_q <= row_q;
				col_out_q <= col_q;
				status_q  <= (sat_q || ovf32(fin)) ? STAT_SAT : STAT_OK;
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign entry_value  = value_q;
	assign row_out      = row_out_q;
	assign col_out      = col_out_q;
	assign entry_status = status_q;

endmodule

### hw/rtl/svm_kernel_matrix_entry.sv
// Reduced LS-SVM kernel matrix entry unit. Feature and q loads and compute requests are
// taken on start while busy is low into a two-beat queue, and are carried out in order.
// A compute request returns one entry on done for exactly one cycle; the receiver cannot
// stall it. An entry reads one feature pair per cycle from the duplicated feature store
// for the nf features in use; the polynomial and radial basis kernels then step the
// single shared multiplier through the power, exponential and Horner divide sequence.
// Indices outside num_points answer with status 1. No clearing pass runs after reset.
`include "svm_kernel_matrix_entry_macros.svh"

module svm_kernel_matrix_entry import skme_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [REQ_W-1:0]        req_type,
	input  logic [PT_W-1:0]         point_index,
	input  logic [FT_W-1:0]         feature_index,
	input  logic signed [VAL_W-1:0] load_value,
	input  logic [PT_W-1:0]         row_index,
	input  logic [PT_W-1:0]         col_index,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [VAL_W-1:0]        cfg_data,
	output logic                    done,
	output logic signed [VAL_W-1:0] entry_value,
	output logic [PT_W-1:0]         row_out,
	output logic [PT_W-1:0]         col_out,
	output logic [STAT_W-1:0]       entry_status
);

	cfg_t              cfg_q;
	item_t             head;
	logic              head_vld, pop;
	logic [NPTS_W-1:0] pts_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_mode   <= '0;
			cfg_q.num_points    <= NPTS_W'(MAX_POINTS);
			cfg_q.feat_use      <= NFEAT_W'(MAX_FEATURES);
			cfg_q.poly_degree   <= DEG_W'(3);
			cfg_q.gamma_value   <= FX_ONE;
			cfg_q.coef_zero     <= '0;
			cfg_q.qa_cost_value <= '0;
			cfg_q.diag_cost     <= FX_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KERNEL_MODE: cfg_q.kernel_mode   <= cfg_data[MODE_W-1:0];
				CFG_NUM_POINTS:  cfg_q.num_points    <= cfg_data[NPTS_W-1:0];
				CFG_NUM_FEAT:    cfg_q.feat_use      <= cfg_data[NFEAT_W-1:0];
				CFG_POLY_DEG:    cfg_q.poly_degree   <= cfg_data[DEG_W-1:0];
				CFG_GAMMA:       cfg_q.gamma_value   <= cfg_data;
				CFG_COEF_ZERO:   cfg_q.coef_zero     <= cfg_data;
				CFG_QA_COST:     cfg_q.qa_cost_value <= cfg_data;
				CFG_DIAG_COST:   cfg_q.diag_cost     <= cfg_data;
				default: ;
			endcase
		end
	end

	skme_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .point_index(point_index), .feature_index(feature_index),
		.load_value(load_value), .row_index(row_index), .col_index(col_index),
		.num_points(cfg_q.num_points), .head(head), .head_vld(head_vld), .pop(pop)
	);

	skme_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head(head), .head_vld(head_vld),
		.pop(pop), .done(done), .entry_value(entry_value), .row_out(row_out),
		.col_out(col_out), .entry_status(entry_status)
	);

	assign pts_lim = (cfg_q.num_points > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS)
		: cfg_q.num_points;

	`SKME_NEVER(a_status_code, done && entry_status != STAT_OK && entry_status != STAT_RANGE && entry_status != STAT_SAT)
	`SKME_IMPLIES(a_range_zero, done && entry_status == STAT_RANGE, entry_value == '0)
	`SKME_IMPLIES(a_in_range, done && entry_status != STAT_RANGE, {1'b0, row_out} < pts_lim && {1'b0, col_out} < pts_lim)

endmodule
